// File: hdl/assert_macros.svh
// assertion helpers used by the shader rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/sdas_pkg.sv
package sdas_pkg;

  typedef struct packed {
    logic [31:0] hit_x;
    logic [31:0] hit_y;
    logic [31:0] hit_z;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic        inside_req;
    logic [7:0]  surface_red;
    logic [7:0]  surface_green;
    logic [7:0]  surface_blue;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } out_t;

  typedef enum logic [7:0] {
    CFG_LIGHT_X    = 8'd0,
    CFG_LIGHT_Y    = 8'd1,
    CFG_LIGHT_Z    = 8'd2,
    CFG_BRIGHTNESS = 8'd3,
    CFG_LIGHT_RGB  = 8'd4,
    CFG_AMBIENT    = 8'd5,
    CFG_AMBIENT_RGB = 8'd6
  } cfg_idx_e;

  localparam int unsigned SqrtSteps = 21;
  localparam int unsigned DivSteps  = 17;
  localparam logic [16:0] IntenOne  = 17'd65536;

  typedef struct packed {
    logic [42:0] x;
    logic [42:0] r;
  } sqrt_st_t;

  // one digit of the floor square root, test bit 4^(20-j)
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int unsigned j);
    sqrt_st_t    o;
    logic [42:0] bitv;
    logic [42:0] trial;
    bitv  = 43'd1 << (40 - 2 * j);
    trial = s.r + bitv;
    if (s.x >= trial) begin
      o.x = s.x - trial;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.x = s.x;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // floor(x / 255) for x below 65025
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// File: hdl/sdas_scale.sv
module sdas_scale (
  input  logic [2:0][32:0] mag_i,
  output logic [2:0][19:0] mag_o,
  output logic             nz_o
);

  logic [32:0] mx;
  logic [5:0]  pos;
  logic [5:0]  shr;
  logic [5:0]  shl;

  always_comb begin
    mx = mag_i[0];
    if (mag_i[1] > mx) mx = mag_i[1];
    if (mag_i[2] > mx) mx = mag_i[2];
    pos = '0;
    for (int b = 0; b < 33; b++) begin
      if (mx[b]) pos = 6'(b);
    end
    nz_o = (mx != '0);
    shr  = (pos > 6'd19) ? pos - 6'd19 : 6'd0;
    shl  = (pos > 6'd19) ? 6'd0 : 6'd19 - pos;
    for (int i = 0; i < 3; i++) begin
      if (pos > 6'd19) mag_o[i] = 20'(mag_i[i] >> shr);
      else mag_o[i] = 20'(mag_i[i] << shl);
    end
  end

endmodule

// File: hdl/sphere_diffuse_ambient_shader.sv
// channel  dir  handshake              payload
// in       in   in_valid_i/in_ready_o  in_data_i  (sdas_pkg::in_t)
// out      out  out_valid_o/out_ready_i out_data_o (sdas_pkg::out_t)
// cfg      in   cfg_we_i               cfg_idx_i, cfg_data_i
// one beat per cycle in and out while out_ready_i is high; 47 register stages
// (scale, dot products, 21 square root digit stages, 17 divider stages, colour)
// each stage holds while the next is full and stalled, bubbles close up during a stall
// reset clears the valid bits and loads the register defaults
`include "assert_macros.svh"

module sphere_diffuse_ambient_shader (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sdas_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sdas_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i
);

  localparam int unsigned SQ0 = 3;
  localparam int unsigned DEN = SQ0 + sdas_pkg::SqrtSteps;
  localparam int unsigned DV0 = DEN + 1;
  localparam int unsigned C0  = DV0 + sdas_pkg::DivSteps + 1;
  localparam int unsigned C1  = C0 + 1;
  localparam int unsigned C2  = C1 + 1;
  localparam int unsigned C3  = C2 + 1;
  localparam int unsigned NST = C3 + 1;

  typedef struct packed {
    sdas_pkg::sqrt_st_t a;
    sdas_pkg::sqrt_st_t b;
    logic signed [42:0] dot;
    logic               ok;
  } sq_rec_t;

  typedef struct packed {
    logic [58:0] rem;
    logic [41:0] den;
    logic [16:0] quo;
    logic        sat;
    logic        ok;
  } dv_rec_t;

  logic signed [31:0] lx_q, ly_q, lz_q;
  logic [16:0] bright_q, amb_q;
  logic [23:0] lrgb_q, argb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q     <= '0;
      ly_q     <= '0;
      lz_q     <= '0;
      bright_q <= 17'd65536;
      lrgb_q   <= 24'hFFFFFF;
      amb_q    <= '0;
      argb_q   <= 24'hFFFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdas_pkg::CFG_LIGHT_X:     lx_q     <= cfg_data_i;
        sdas_pkg::CFG_LIGHT_Y:     ly_q     <= cfg_data_i;
        sdas_pkg::CFG_LIGHT_Z:     lz_q     <= cfg_data_i;
        sdas_pkg::CFG_BRIGHTNESS:  bright_q <= cfg_data_i[16:0];
        sdas_pkg::CFG_LIGHT_RGB:   lrgb_q   <= cfg_data_i[23:0];
        sdas_pkg::CFG_AMBIENT:     amb_q    <= cfg_data_i[16:0];
        sdas_pkg::CFG_AMBIENT_RGB: argb_q   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // stage control
  logic [NST-1:0] v_q;
  logic [NST-1:0] ce;

  always_comb begin
    ce[NST-1] = ~v_q[NST-1] | out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      ce[k] = ~v_q[k] | ce[k+1];
    end
  end

  assign in_ready_o  = ce[0];
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ce[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (ce[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  logic [23:0] surf_q [C0];

  always_ff @(posedge clk_i) begin
    if (ce[0]) surf_q[0] <= {in_data_i.surface_red, in_data_i.surface_green,
                             in_data_i.surface_blue};
    for (int k = 1; k < C0; k++) begin
      if (ce[k]) surf_q[k] <= surf_q[k-1];
    end
  end

  // stage 0: difference vectors as sign and magnitude
  logic [2:0][32:0] mn_q, ml_q;
  logic [2:0]       sn_q, sl_q;
  logic [2:0][31:0] hit_c, ctr_c, lp_c;

  assign hit_c = {in_data_i.hit_z, in_data_i.hit_y, in_data_i.hit_x};
  assign ctr_c = {in_data_i.center_z, in_data_i.center_y, in_data_i.center_x};
  assign lp_c  = {lz_q, ly_q, lx_q};

  always_ff @(posedge clk_i) begin
    if (ce[0]) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [32:0] dn, dl;
        dn = $signed({hit_c[i][31], hit_c[i]}) - $signed({ctr_c[i][31], ctr_c[i]});
        dl = $signed({lp_c[i][31], lp_c[i]}) - $signed({hit_c[i][31], hit_c[i]});
        mn_q[i] <= dn[32] ? 33'(-dn) : 33'(dn);
        sn_q[i] <= dn[32] ^ in_data_i.inside_req;
        ml_q[i] <= dl[32] ? 33'(-dl) : 33'(dl);
        sl_q[i] <= dl[32];
      end
    end
  end

  // stage 1: common scaling
  logic [2:0][19:0] an_c, al_c, an_q, al_q;
  logic             nzn_c, nzl_c, nzn_q, nzl_q;
  logic [2:0]       sn1_q, sl1_q;

  sdas_scale u_scale_n (.mag_i(mn_q), .mag_o(an_c), .nz_o(nzn_c));
  sdas_scale u_scale_l (.mag_i(ml_q), .mag_o(al_c), .nz_o(nzl_c));

  always_ff @(posedge clk_i) begin
    if (ce[1]) begin
      an_q  <= an_c;
      al_q  <= al_c;
      nzn_q <= nzn_c;
      nzl_q <= nzl_c;
      sn1_q <= sn_q;
      sl1_q <= sl_q;
    end
  end

  // stage 2: dot product and squared lengths
  logic [41:0]        qa_q, qb_q;
  logic signed [42:0] dot_q;
  logic               ok2_q;

  always_ff @(posedge clk_i) begin
    if (ce[2]) begin
      logic [41:0]        sa, sb;
      logic signed [42:0] sd;
      logic [39:0]        p, pa, pb;
      sa = '0;
      sb = '0;
      sd = '0;
      for (int i = 0; i < 3; i++) begin
        p  = an_q[i] * al_q[i];
        pa = an_q[i] * an_q[i];
        pb = al_q[i] * al_q[i];
        sa = sa + {2'b00, pa};
        sb = sb + {2'b00, pb};
        if (sn1_q[i] ^ sl1_q[i]) sd = sd - $signed({3'b000, p});
        else sd = sd + $signed({3'b000, p});
      end
      qa_q  <= sa;
      qb_q  <= sb;
      dot_q <= sd;
      ok2_q <= nzn_q & nzl_q;
    end
  end

  // square roots, one digit per stage
  sq_rec_t sq_q [sdas_pkg::SqrtSteps];

  always_ff @(posedge clk_i) begin
    if (ce[SQ0]) begin
      sq_q[0].a   <= sdas_pkg::sqrt_step('{x: {1'b0, qa_q}, r: '0}, 0);
      sq_q[0].b   <= sdas_pkg::sqrt_step('{x: {1'b0, qb_q}, r: '0}, 0);
      sq_q[0].dot <= dot_q;
      sq_q[0].ok  <= ok2_q;
    end
    for (int j = 1; j < sdas_pkg::SqrtSteps; j++) begin
      if (ce[SQ0+j]) begin
        sq_q[j].a   <= sdas_pkg::sqrt_step(sq_q[j-1].a, j);
        sq_q[j].b   <= sdas_pkg::sqrt_step(sq_q[j-1].b, j);
        sq_q[j].dot <= sq_q[j-1].dot;
        sq_q[j].ok  <= sq_q[j-1].ok;
      end
    end
  end

  // norm product and numerator
  logic [41:0] den_q;
  logic [57:0] num_q;
  logic        okd_q;

  always_ff @(posedge clk_i) begin
    if (ce[DEN]) begin
      den_q <= sq_q[sdas_pkg::SqrtSteps-1].a.r[20:0] * sq_q[sdas_pkg::SqrtSteps-1].b.r[20:0];
      num_q <= {sq_q[sdas_pkg::SqrtSteps-1].dot[41:0], 16'd0};
      okd_q <= sq_q[sdas_pkg::SqrtSteps-1].ok & (sq_q[sdas_pkg::SqrtSteps-1].dot > 0);
    end
  end

  // restoring divider, one quotient bit per stage
  dv_rec_t dv_q [sdas_pkg::DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (ce[DV0]) begin
      dv_q[0].rem <= {1'b0, num_q};
      dv_q[0].den <= den_q;
      dv_q[0].quo <= '0;
      dv_q[0].sat <= ({1'b0, num_q} >= {den_q, 17'd0});
      dv_q[0].ok  <= okd_q & (den_q != '0);
    end
    for (int k = 1; k <= sdas_pkg::DivSteps; k++) begin
      if (ce[DV0+k]) begin
        logic [58:0] cmp;
        dv_rec_t     nx;
        cmp = 59'(dv_q[k-1].den) << (sdas_pkg::DivSteps - k);
        nx  = dv_q[k-1];
        if (nx.rem >= cmp) begin
          nx.rem = nx.rem - cmp;
          nx.quo[sdas_pkg::DivSteps-k] = 1'b1;
        end
        dv_q[k] <= nx;
      end
    end
  end

  // colour stages
  logic [16:0] inten_c;
  dv_rec_t     dvl;

  assign dvl = dv_q[sdas_pkg::DivSteps];

  always_comb begin
    if (!dvl.ok) inten_c = '0;
    else if (dvl.sat || dvl.quo > sdas_pkg::IntenOne) inten_c = sdas_pkg::IntenOne;
    else inten_c = dvl.quo;
  end

  logic [2:0][24:0] sb_q, sa_q;
  logic [2:0][32:0] sbl_q, saa_q, saa2_q;
  logic [2:0][49:0] t1_q;
  logic [16:0]      inten_q, inten1_q;
  sdas_pkg::out_t   out_q;

  always_ff @(posedge clk_i) begin
    if (ce[C0]) begin
      for (int i = 0; i < 3; i++) begin
        sb_q[i] <= surf_q[C0-1][8*(2-i) +: 8] * bright_q;
        sa_q[i] <= surf_q[C0-1][8*(2-i) +: 8] * amb_q;
      end
      inten_q <= inten_c;
    end
    if (ce[C1]) begin
      for (int i = 0; i < 3; i++) begin
        sbl_q[i] <= sb_q[i] * lrgb_q[8*(2-i) +: 8];
        saa_q[i] <= sa_q[i] * argb_q[8*(2-i) +: 8];
      end
      inten1_q <= inten_q;
    end
    if (ce[C2]) begin
      for (int i = 0; i < 3; i++) begin
        t1_q[i]   <= sbl_q[i] * inten1_q;
        saa2_q[i] <= saa_q[i];
      end
    end
    if (ce[C3]) begin
      logic [50:0] num;
      logic [18:0] qh;
      logic [2:0][7:0] ch;
      for (int i = 0; i < 3; i++) begin
        num = 51'(t1_q[i]) + (51'(saa2_q[i]) << 16);
        qh  = num[50:32];
        ch[i] = (qh >= 19'd65025) ? 8'd255 : sdas_pkg::div255(qh[15:0]);
      end
      out_q.pixel_red   <= ch[0];
      out_q.pixel_green <= ch[1];
      out_q.pixel_blue  <= ch[2];
    end
  end

  assign out_data_o = out_q;

  `ASSERT_IMPLIES(a_stall_only_at_out, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  `ASSERT_IMPLIES(a_inten_range, clk_i, rst_ni, v_q[C0-1], inten_c <= sdas_pkg::IntenOne)
  `ASSERT_IMPLIES(a_scale_top, clk_i, rst_ni, v_q[1] && nzn_q,
                  an_q[0][19] || an_q[1][19] || an_q[2][19])

endmodule

// File: tb/sv/tb_sphere_diffuse_ambient_shader.sv
`timescale 1ns / 100ps

module tb_sphere_diffuse_ambient_shader;

  localparam int unsigned Latency    = 47;
  localparam int unsigned NumRandom  = 850;
  localparam int unsigned WatchLimit = 20000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  sdas_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  sdas_pkg::out_t out_data_o;
  logic           cfg_we_i = 1'b0;
  logic [7:0]     cfg_idx_i = '0;
  logic [31:0]    cfg_data_i = '0;

  sphere_diffuse_ambient_shader u_dut (.*);

  always #5 clk_i = ~clk_i;

  // shading registers, as the block should hold them
  logic [31:0] light_x, light_y, light_z;
  logic [16:0] bright, amb;
  logic [23:0] light_rgb, amb_rgb;

  typedef struct {
    sdas_pkg::in_t  stim;
    logic           check_fixed;
    sdas_pkg::out_t fixed;
  } row_t;

  sdas_pkg::out_t pixel_q[$];
  int unsigned errors = 0;
  int unsigned n_out = 0;
  int unsigned n_in = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_cfg = 0;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;

  task automatic report(string what, logic [7:0] got, logic [7:0] exp_v);
    $display("mismatch %s at pixel %0d: got %0d expected %0d", what, n_out, got, exp_v);
    errors++;
  endtask

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // bring the largest magnitude into [2^19, 2^20), keeping signs
  function automatic bit normalise(input longint d[3], output longint v[3]);
    longint unsigned m[3], mx, s;
    int sh, up;
    mx = 0;
    sh = 0;
    up = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i] < 0 ? -d[i] : d[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while ((mx >> sh) >= (64'd1 << 20)) sh++;
    if (sh == 0) while ((mx << up) < (64'd1 << 19)) up++;
    for (int i = 0; i < 3; i++) begin
      s = sh > 0 ? m[i] >> sh : m[i] << up;
      v[i] = d[i] < 0 ? -longint'(s) : longint'(s);
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] channel(logic [7:0] s, logic [7:0] lc, logic [7:0] ac,
                                         logic [63:0] inten);
    logic [63:0] num, q;
    num = 64'(s) * bright * lc * inten + 64'(s) * amb * ac * 64'd65536;
    q = num / (64'd255 << 32);
    return q > 255 ? 8'd255 : q[7:0];
  endfunction

  function automatic sdas_pkg::out_t shade(sdas_pkg::in_t t);
    longint         hit[3], ctr[3], lp[3], dn[3], dl[3], a[3], b[3], dot;
    logic [63:0]    qa, qb, na, nb, inten;
    sdas_pkg::out_t o;
    inten = 0;
    hit = '{longint'($signed(t.hit_x)), longint'($signed(t.hit_y)),
            longint'($signed(t.hit_z))};
    ctr = '{longint'($signed(t.center_x)), longint'($signed(t.center_y)),
            longint'($signed(t.center_z))};
    lp = '{longint'($signed(light_x)), longint'($signed(light_y)),
           longint'($signed(light_z))};
    for (int i = 0; i < 3; i++) begin
      dn[i] = hit[i] - ctr[i];
      dl[i] = lp[i] - hit[i];
      if (t.inside_req) dn[i] = -dn[i];
    end
    if (normalise(dn, a) && normalise(dl, b)) begin
      dot = 0;
      qa = 0;
      qb = 0;
      for (int i = 0; i < 3; i++) begin
        dot += a[i] * b[i];
        qa += a[i] * a[i];
        qb += b[i] * b[i];
      end
      na = root_floor(qa);
      nb = root_floor(qb);
      if (dot > 0 && na != 0 && nb != 0) begin
        inten = (64'(dot) << 16) / (na * nb);
        if (inten > 65536) inten = 65536;
      end
    end
    o.pixel_red   = channel(t.surface_red, light_rgb[23:16], amb_rgb[23:16], inten);
    o.pixel_green = channel(t.surface_green, light_rgb[15:8], amb_rgb[15:8], inten);
    o.pixel_blue  = channel(t.surface_blue, light_rgb[7:0], amb_rgb[7:0], inten);
    return o;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(sdas_pkg::cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sdas_pkg::CFG_LIGHT_X:     light_x = val;
      sdas_pkg::CFG_LIGHT_Y:     light_y = val;
      sdas_pkg::CFG_LIGHT_Z:     light_z = val;
      sdas_pkg::CFG_BRIGHTNESS:  bright = val[16:0];
      sdas_pkg::CFG_LIGHT_RGB:   light_rgb = val[23:0];
      sdas_pkg::CFG_AMBIENT:     amb = val[16:0];
      sdas_pkg::CFG_AMBIENT_RGB: amb_rgb = val[23:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sender: holds valid and payload until accepted, valid stays up between beats unless a random gap is drawn
  task automatic send(sdas_pkg::in_t t, sdas_pkg::out_t pix);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_data_i <= t;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pixel_q.push_back(pix);
    n_in++;
    @(negedge clk_i);
  endtask

  function automatic sdas_pkg::in_t rand_hit(bit near);
    sdas_pkg::in_t t;
    logic [223:0]  raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    t = raw[$bits(sdas_pkg::in_t)-1:0];
    if (near) begin
      // centre within half a unit of the hit on each axis, so the cosine covers its whole range
      t.hit_x = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
      t.hit_y = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
      t.hit_z = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
      t.center_x = t.hit_x + $signed($urandom_range(0, 16'hFFFF)) - 32'sh8000;
      t.center_y = t.hit_y + $signed($urandom_range(0, 16'hFFFF)) - 32'sh8000;
      t.center_z = t.hit_z + $signed($urandom_range(0, 16'hFFFF)) - 32'sh8000;
    end
    return t;
  endfunction

  // receiver with random stalls and one long hold-off
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else begin
        g = gap_len();
        if (g == 0) out_ready_i <= 1'b1;
        else begin
          out_ready_i <= 1'b0;
          repeat (g - 1) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        $display("unexpected pixel %0d", n_out);
        errors++;
      end else begin
        sdas_pkg::out_t e;
        e = pixel_q.pop_front();
        if (out_data_o.pixel_red !== e.pixel_red)
          report("red", out_data_o.pixel_red, e.pixel_red);
        if (out_data_o.pixel_green !== e.pixel_green)
          report("green", out_data_o.pixel_green, e.pixel_green);
        if (out_data_o.pixel_blue !== e.pixel_blue)
          report("blue", out_data_o.pixel_blue, e.pixel_blue);
      end
      n_out++;
    end
  end

  // watchdog on cycles with no beat on either side and no register write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i || stim_done
        || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    row_t          rows[$];
    row_t          r;
    sdas_pkg::in_t t;
    int unsigned   n;
    light_x = 0; light_y = 0; light_z = 0;
    bright = 17'd65536; light_rgb = 24'hFFFFFF;
    amb = 0; amb_rgb = 24'hFFFFFF;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: light at origin after reset
    t = '0;
    t.surface_red = 8'd255; t.surface_green = 8'd255; t.surface_blue = 8'd255;
    // hit equals centre: no diffuse, ambient off
    rows.push_back('{t, 1'b1, sdas_pkg::out_t'('0)});
    // normal +x at x=-1, light at origin: full cosine
    t.hit_x = -32'sh10000; t.center_x = -32'sh20000;
    rows.push_back('{t, 1'b1, sdas_pkg::out_t'({8'd255, 8'd255, 8'd255})});
    // inside flag turns the normal away
    t.inside_req = 1'b1;
    rows.push_back('{t, 1'b1, sdas_pkg::out_t'('0)});
    t.inside_req = 1'b0;
    t.surface_red = 8'd0; t.surface_green = 8'd128; t.surface_blue = 8'd1;
    rows.push_back('{t, 1'b0, sdas_pkg::out_t'('0)});
    // light equals hit
    t = '0; t.center_x = 32'sh10000; t.surface_green = 8'hFF;
    rows.push_back('{t, 1'b1, sdas_pkg::out_t'('0)});
    // coordinate extremes
    t = '1;
    t.hit_x = 32'h7FFFFFFF; t.hit_y = 32'h80000000; t.hit_z = 32'h7FFFFFFF;
    t.center_x = 32'h80000000; t.center_y = 32'h7FFFFFFF; t.center_z = 32'h80000000;
    rows.push_back('{t, 1'b0, sdas_pkg::out_t'('0)});
    t.inside_req = 1'b0;
    rows.push_back('{t, 1'b0, sdas_pkg::out_t'('0)});
    t.hit_x = 32'h80000000; t.center_x = 32'h7FFFFFFF;
    rows.push_back('{t, 1'b0, sdas_pkg::out_t'('0)});
    t = '0; t.hit_y = 32'sh1; t.center_y = 32'sh0; t.surface_blue = 8'd200;
    rows.push_back('{t, 1'b0, sdas_pkg::out_t'('0)});
    for (int i = 0; i < 6; i++) rows.push_back('{rand_hit(1'b1), 1'b0, sdas_pkg::out_t'('0)});

    foreach (rows[i]) begin
      r = rows[i];
      send(r.stim, r.check_fixed ? r.fixed : shade(r.stim));
    end
    wait_drained();

    // ambient extremes and above-one ratios
    write_reg(sdas_pkg::CFG_AMBIENT, 32'd65536);
    write_reg(sdas_pkg::CFG_AMBIENT_RGB, 32'h00FF8000);
    t = '0; t.surface_red = 8'd255; t.surface_green = 8'd255; t.surface_blue = 8'd255;
    send(t, sdas_pkg::out_t'({8'd255, 8'd128, 8'd0}));
    wait_drained();
    write_reg(sdas_pkg::CFG_BRIGHTNESS, 32'h1FFFF);
    write_reg(sdas_pkg::CFG_AMBIENT, 32'h1FFFF);
    write_reg(sdas_pkg::CFG_LIGHT_RGB, 32'h0000FF7F);
    write_reg(sdas_pkg::CFG_LIGHT_X, 32'h7FFFFFFF);
    write_reg(sdas_pkg::CFG_LIGHT_Y, 32'h80000000);
    write_reg(sdas_pkg::CFG_LIGHT_Z, 32'sh30000);
    for (int i = 0; i < 5; i++) begin
      t = rand_hit(i[0]);
      send(t, shade(t));
    end
    wait_drained();

    // random phases, each with new register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(sdas_pkg::CFG_BRIGHTNESS, 32'd0); write_reg(sdas_pkg::CFG_AMBIENT, 32'd0);
        end
        1: begin
          write_reg(sdas_pkg::CFG_BRIGHTNESS, 32'd65536);
          write_reg(sdas_pkg::CFG_AMBIENT, 32'd0);
          write_reg(sdas_pkg::CFG_LIGHT_RGB, 32'h00FFFFFF);
          write_reg(sdas_pkg::CFG_LIGHT_X, 32'd0);
          write_reg(sdas_pkg::CFG_LIGHT_Y, 32'd0);
          write_reg(sdas_pkg::CFG_LIGHT_Z, 32'd0);
        end
        default: begin
          write_reg(sdas_pkg::CFG_LIGHT_X,
                    $signed($urandom_range(0, 22'h3FFFFF)) - 32'sh200000);
          write_reg(sdas_pkg::CFG_LIGHT_Y,
                    $signed($urandom_range(0, 22'h3FFFFF)) - 32'sh200000);
          write_reg(sdas_pkg::CFG_LIGHT_Z, ph == 7 ? $urandom : 32'h00050000);
          write_reg(sdas_pkg::CFG_BRIGHTNESS, $urandom_range(0, 17'h1FFFF));
          write_reg(sdas_pkg::CFG_LIGHT_RGB, $urandom);
          write_reg(sdas_pkg::CFG_AMBIENT, $urandom_range(0, 65536));
          write_reg(sdas_pkg::CFG_AMBIENT_RGB, $urandom);
        end
      endcase
      n = NumRandom / 8;
      for (int i = 0; i < n; i++) begin
        if (ph == 3 && i == 10) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (Latency * 3) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        t = rand_hit($urandom_range(0, 9) < 8);
        send(t, shade(t));
      end
      wait_drained();
    end

    stim_done = 1'b1;
    repeat (Latency) @(posedge clk_i);
    $display("sent %0d hits, checked %0d pixels, %0d register writes over 11 settings",
             n_in, n_out, n_cfg);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/sdas_pkg.sv
hdl/sdas_scale.sv
hdl/sphere_diffuse_ambient_shader.sv
tb/sv/tb_sphere_diffuse_ambient_shader.sv
